[rtl/gpps_pkg.sv]
// Shared constants, phase codes and types of the gait phase perturbation sequencer.
`timescale 1ns / 1ps
`default_nettype none

package gpps_pkg;

  localparam int WINDOW_LEN_DEF = 5;
  localparam int POS_WIDTH_DEF  = 16;
  localparam int DIST_WIDTH     = 16;
  localparam int TYPE_WIDTH     = 2;
  localparam int PHASE_WIDTH    = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [PHASE_WIDTH-1:0] PH_APPROACH    = 3'd0;
  localparam logic [PHASE_WIDTH-1:0] PH_AWAIT_FWD   = 3'd1;
  localparam logic [PHASE_WIDTH-1:0] PH_IN_FWD      = 3'd2;
  localparam logic [PHASE_WIDTH-1:0] PH_PERTURB     = 3'd3;
  localparam logic [PHASE_WIDTH-1:0] PH_AWAIT_CLEAR = 3'd4;
  localparam logic [PHASE_WIDTH-1:0] PH_HALTED      = 3'd5;

  localparam logic [TYPE_WIDTH-1:0] TYPE_NONE = 2'd0;

  // One classified sample as handed from the front end to the sequencer.
  typedef struct packed {
    logic                  halt;
    logic                  fwd;
    logic                  bwd;
    logic                  dist_le0;
    logic                  dist_ge0;
    logic [TYPE_WIDTH-1:0] ptype;
  } cls_t;

  // Queue handshake between the front end and the queue.
  typedef struct packed {
    logic push;
    cls_t data;
  } push_t;

  // Queue head as seen by the sequencer.
  typedef struct packed {
    logic avail;
    cls_t data;
  } head_t;

endpackage

`default_nettype wire

[rtl/gpps_in_if.sv]
// Input channel interface: one foot sample with patch information per item.
`timescale 1ns / 1ps
`default_nettype none

interface gpps_in_if
  import gpps_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [POS_WIDTH-1:0]  foot_position;
  logic signed [DIST_WIDTH-1:0] patch_distance;
  logic [TYPE_WIDTH-1:0]        patch_type;
  logic                         quit_request;

  modport source (output valid, foot_position, patch_distance, patch_type, quit_request,
                  input ready);
  modport sink   (input valid, foot_position, patch_distance, patch_type, quit_request,
                  output ready);
endinterface

`default_nettype wire

[rtl/gpps_out_if.sv]
// Output channel interface: one sequencer result per item.
`timescale 1ns / 1ps
`default_nettype none

interface gpps_out_if
  import gpps_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [TYPE_WIDTH-1:0]  perturb_level;
  logic                   moving_forward;
  logic                   moving_backward;
  logic [PHASE_WIDTH-1:0] phase;
  logic                   patch_done;

  modport source (output valid, perturb_level, moving_forward, moving_backward, phase,
                  patch_done, input ready);
  modport sink   (input valid, perturb_level, moving_forward, moving_backward, phase,
                  patch_done, output ready);
endinterface

`default_nettype wire

[rtl/gait_phase_perturbation_sequencer.sv]
// An accepted sample goes into the queue, then is popped into the registered phase and result.
// Throughput: one item per cycle unless output stalls; the window compare is combinational.
// The front end stalls only when the two-entry queue is full; the sequencer stalls on output.
// Reset (rst, synchronous) clears the window, flags, phase, queue and output valid.
// After a quit request every later item returns phase halted with the held outputs.
`timescale 1ns / 1ps
`default_nettype none

module gait_phase_perturbation_sequencer
  import gpps_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gpps_in_if.sink    samples,
  gpps_out_if.source results
);

  push_t push;
  head_t head;
  logic  queue_full;
  logic  pop;

  gpps_front #(
    .WINDOW_LEN (WINDOW_LEN),
    .POS_WIDTH  (POS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .queue_full (queue_full),
    .push       (push)
  );

  gpps_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  gpps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

`default_nettype wire

[rtl/gpps_front.sv]
// Front end: accepts samples, keeps the position window and classifies the motion.
`timescale 1ns / 1ps
`default_nettype none

module gpps_front
  import gpps_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gpps_in_if.sink    samples,
  input  wire logic  queue_full,
  output push_t      push
);

  logic signed [POS_WIDTH-1:0] window [WINDOW_LEN];
  logic signed [POS_WIDTH-1:0] window_next [WINDOW_LEN];
  logic                        halted;
  logic                        accept;
  logic                        halt_now;
  logic                        nondec;
  logic                        noninc;

  assign samples.ready = !queue_full;
  assign accept        = samples.valid && samples.ready;
  assign halt_now      = halted || samples.quit_request;

  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      window_next[i] = window[i + 1];
    end
    window_next[WINDOW_LEN - 1] = samples.foot_position;
  end

  // Each adjacent pair is compared independently, then the results are reduced.
  always_comb begin
    nondec = 1'b1;
    noninc = 1'b1;
    for (int i = 1; i < WINDOW_LEN; i++) begin
      if (window_next[i] < window_next[i - 1]) begin
        nondec = 1'b0;
      end
      if (window_next[i] > window_next[i - 1]) begin
        noninc = 1'b0;
      end
    end
  end

  always_comb begin
    push.push          = accept;
    push.data.halt     = halt_now;
    push.data.bwd      = nondec;
    push.data.fwd      = !nondec && noninc;
    push.data.dist_le0 = samples.patch_distance[DIST_WIDTH-1] ||
                         (samples.patch_distance == '0);
    push.data.dist_ge0 = !samples.patch_distance[DIST_WIDTH-1];
    push.data.ptype    = samples.patch_type;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      // Once halted the window is frozen until reset.
      if (halt_now) begin
        halted <= 1'b1;
      end else begin
        window <= window_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/gpps_queue.sv]
// Short queue of classified samples between the front end and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module gpps_queue
  import gpps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  push_t     push,
  output logic      full,
  output head_t     head,
  input  wire logic pop
);

  cls_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head.avail = (count != '0);
  assign head.data  = entries[rd_ptr];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/gpps_back.sv]
// Back end: phase sequencer and the registered result output.
`timescale 1ns / 1ps
`default_nettype none

module gpps_back
  import gpps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  head_t      head,
  output logic       pop,
  gpps_out_if.source results
);

  logic [PHASE_WIDTH-1:0] phase;
  logic [PHASE_WIDTH-1:0] phase_next;
  logic [TYPE_WIDTH-1:0]  perturb;
  logic [TYPE_WIDTH-1:0]  perturb_next;
  logic [TYPE_WIDTH-1:0]  latched;
  logic [TYPE_WIDTH-1:0]  latched_next;
  logic                   hold_fwd;
  logic                   hold_bwd;
  logic                   fwd_next;
  logic                   bwd_next;
  logic                   done_next;
  logic                   out_valid;
  logic                   out_free;
  cls_t                   r;

  assign r        = head.data;
  assign out_free = !out_valid || results.ready;
  assign pop      = head.avail && out_free;

  always_comb begin
    phase_next   = phase;
    perturb_next = perturb;
    latched_next = latched;
    fwd_next     = r.fwd;
    bwd_next     = r.bwd;
    done_next    = 1'b0;
    if (r.halt || (phase == PH_HALTED)) begin
      // Flags and perturb level stay as they were before the halt.
      phase_next = PH_HALTED;
      fwd_next   = hold_fwd;
      bwd_next   = hold_bwd;
    end else begin
      case (phase)
        PH_APPROACH: begin
          if (r.dist_le0 && (r.ptype != TYPE_NONE)) begin
            latched_next = r.ptype;
            phase_next   = PH_AWAIT_FWD;
          end
        end
        PH_AWAIT_FWD: begin
          if (r.fwd) begin
            phase_next = PH_IN_FWD;
          end
        end
        PH_IN_FWD: begin
          if (!r.fwd) begin
            perturb_next = latched;
            phase_next   = PH_PERTURB;
          end
        end
        PH_PERTURB: begin
          if (r.fwd) begin
            perturb_next = TYPE_NONE;
            phase_next   = PH_AWAIT_CLEAR;
          end
        end
        PH_AWAIT_CLEAR: begin
          if (r.dist_ge0) begin
            phase_next = PH_APPROACH;
            done_next  = 1'b1;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_APPROACH;
      perturb   <= TYPE_NONE;
      latched   <= TYPE_NONE;
      hold_fwd  <= 1'b0;
      hold_bwd  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase     <= phase_next;
        perturb   <= perturb_next;
        latched   <= latched_next;
        hold_fwd  <= fwd_next;
        hold_bwd  <= bwd_next;
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.perturb_level   <= perturb_next;
      results.moving_forward  <= fwd_next;
      results.moving_backward <= bwd_next;
      results.phase           <= phase_next;
      results.patch_done      <= done_next;
    end
  end

  assign results.valid = out_valid;

endmodule

`default_nettype wire

[rtl/gpps_checker.sv]
// Port-level checks of the sequencer results, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gpps_checker
  import gpps_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [TYPE_WIDTH-1:0]  perturb_level,
  input wire logic                   moving_forward,
  input wire logic                   moving_backward,
  input wire logic [PHASE_WIDTH-1:0] phase,
  input wire logic                   patch_done
);

  logic seen_halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (out_valid && out_ready && (phase == PH_HALTED)) begin
      seen_halt <= 1'b1;
    end
  end

  // Only reset leaves the halted phase.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seen_halt) |-> (phase == PH_HALTED))
    else $error("result left halted phase without reset");

  a_perturb_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase != PH_PERTURB) && (phase != PH_HALTED)) |-> (perturb_level == TYPE_NONE))
    else $error("perturb level set outside perturbing phase");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(moving_forward && moving_backward))
    else $error("both motion flags set");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && patch_done) |-> (phase == PH_APPROACH))
    else $error("patch done outside approach phase");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result item dropped while stalled");

endmodule

bind gait_phase_perturbation_sequencer gpps_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .perturb_level   (results.perturb_level),
  .moving_forward  (results.moving_forward),
  .moving_backward (results.moving_backward),
  .phase           (results.phase),
  .patch_done      (results.patch_done)
);

`default_nettype wire

[tb/gait_phase_perturbation_sequencer_test.sv]
// Self-checking testbench for the gait phase perturbation sequencer.
`timescale 1ns / 1ps

module gait_phase_perturbation_sequencer_test;
  import gpps_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SAMPLE_TARGET  = 1950;
  localparam int HOLD_AT_RESULT = 500;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 10;

  // Classes of patch distance for the stimulus.
  localparam int DIST_ABOVE = 0;
  localparam int DIST_OVER  = 1;
  localparam int DIST_CLEAR = 2;
  localparam int DIST_ANY   = 3;

  // Directions of the foot walk; noise jumps anywhere in the range.
  localparam int DIR_FWD   = -1;
  localparam int DIR_HOLD  = 0;
  localparam int DIR_BACK  = 1;
  localparam int DIR_NOISE = 2;

  typedef struct packed {
    logic [TYPE_WIDTH-1:0]  level;
    logic                   fwd;
    logic                   bwd;
    logic [PHASE_WIDTH-1:0] phase;
    logic                   done;
  } gait_result_t;

  class gait_scoreboard;
    logic signed [POS_WIDTH_DEF-1:0] window [WINDOW_LEN_DEF];
    logic                            fwd;
    logic                            bwd;
    logic [PHASE_WIDTH-1:0]          phase;
    logic [TYPE_WIDTH-1:0]           level;
    logic [TYPE_WIDTH-1:0]           latched;
    gait_result_t                    expected_q[$];
    int                              errors;

    function new();
      foreach (window[i]) window[i] = '0;
      fwd     = 1'b0;
      bwd     = 1'b0;
      phase   = PH_APPROACH;
      level   = TYPE_NONE;
      latched = TYPE_NONE;
      errors  = 0;
    endfunction

    // Advances the sequencer by one accepted sample and queues its result.
    function void note_sample(logic signed [POS_WIDTH_DEF-1:0] pos,
                              logic signed [DIST_WIDTH-1:0] distance,
                              logic [TYPE_WIDTH-1:0] ptype, logic quit);
      gait_result_t r;
      logic         done;
      bit           nondec;
      bit           noninc;
      done = 1'b0;
      if (phase != PH_HALTED && quit) phase = PH_HALTED;
      if (phase != PH_HALTED) begin
        for (int i = 1; i < WINDOW_LEN_DEF; i++) window[i-1] = window[i];
        window[WINDOW_LEN_DEF-1] = pos;
        nondec = 1'b1;
        noninc = 1'b1;
        for (int i = 1; i < WINDOW_LEN_DEF; i++) begin
          if (window[i] < window[i-1]) nondec = 1'b0;
          if (window[i] > window[i-1]) noninc = 1'b0;
        end
        // A flat window counts as non-decreasing, so it reads as backward.
        bwd = nondec;
        fwd = !nondec && noninc;
        case (phase)
          PH_APPROACH: begin
            if (distance <= 0 && ptype != TYPE_NONE) begin
              latched = ptype;
              phase   = PH_AWAIT_FWD;
            end
          end
          PH_AWAIT_FWD: begin
            if (fwd) phase = PH_IN_FWD;
          end
          PH_IN_FWD: begin
            if (!fwd) begin
              level = latched;
              phase = PH_PERTURB;
            end
          end
          PH_PERTURB: begin
            if (fwd) begin
              level = TYPE_NONE;
              phase = PH_AWAIT_CLEAR;
            end
          end
          PH_AWAIT_CLEAR: begin
            if (distance >= 0) begin
              phase = PH_APPROACH;
              done  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      r.level = level;
      r.fwd   = fwd;
      r.bwd   = bwd;
      r.phase = phase;
      r.done  = done;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(gait_result_t got);
      gait_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare_field("perturb_level", want.level, got.level);
        compare_field("moving_forward", want.fwd, got.fwd);
        compare_field("moving_backward", want.bwd, got.bwd);
        compare_field("phase", want.phase, got.phase);
        compare_field("patch_done", want.done, got.done);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  gpps_in_if #(.POS_WIDTH(POS_WIDTH_DEF)) samples_ch ();
  gpps_out_if results_ch ();

  gait_phase_perturbation_sequencer dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch)
  );

  gait_scoreboard sb = new();

  int samples_sent = 0;
  int results_seen = 0;
  int cur_pos      = 0;
  bit send_burst   = 1'b0;
  bit recv_burst   = 1'b0;

  always #5 clk = ~clk;

  initial begin
    samples_ch.valid          = 1'b0;
    samples_ch.foot_position  = '0;
    samples_ch.patch_distance = '0;
    samples_ch.patch_type     = TYPE_NONE;
    samples_ch.quit_request   = 1'b0;
    results_ch.ready          = 1'b0;
  end

  // Offers one sample after a random gap and returns once it is accepted.
  task automatic send_sample(input logic [POS_WIDTH_DEF-1:0] pos,
                             input logic [DIST_WIDTH-1:0] distance,
                             input logic [TYPE_WIDTH-1:0] ptype, input logic quit);
    int gap;
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      samples_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_ch.foot_position  = pos;
    samples_ch.patch_distance = distance;
    samples_ch.patch_type     = ptype;
    samples_ch.quit_request   = quit;
    samples_ch.valid          = 1'b1;
    do @(posedge clk); while (!samples_ch.ready);
    sb.note_sample(pos, distance, ptype, quit);
    samples_sent++;
  endtask

  function automatic logic [DIST_WIDTH-1:0] pick_distance(int kind);
    int sel;
    int v;
    sel = $urandom_range(0, 3);
    case (kind)
      DIST_ABOVE: v = (sel == 0) ? 32767 : $urandom_range(1, 32767);
      DIST_OVER:  v = (sel == 0) ? 0 : (sel == 1) ? -32768 : -int'($urandom_range(1, 32768));
      DIST_CLEAR: v = (sel == 0) ? 0 : $urandom_range(0, 32767);
      default:    v = $urandom_range(0, 65535);
    endcase
    return v[DIST_WIDTH-1:0];
  endfunction

  // Walks the foot n samples in one direction with random step sizes, or at random in noise mode.
  task automatic stride(input int n, input int dir, input int dist_kind,
                        input logic [TYPE_WIDTH-1:0] ptype);
    logic signed [POS_WIDTH_DEF-1:0] jump;
    int                              step;
    for (int k = 0; k < n; k++) begin
      if (dir == DIR_NOISE) begin
        jump    = POS_WIDTH_DEF'($urandom);
        cur_pos = int'(jump);
      end else begin
        step    = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3000);
        cur_pos = cur_pos + dir * step;
        if (cur_pos > 32767) cur_pos = 32767;
        if (cur_pos < -32768) cur_pos = -32768;
      end
      send_sample(cur_pos[POS_WIDTH_DEF-1:0], pick_distance(dist_kind), ptype, 1'b0);
    end
  endtask

  // One patch crossing: approach, step onto the patch, swing forward, step back,
  // swing forward again and leave the patch.
  task automatic gait_cycle();
    logic [TYPE_WIDTH-1:0] over_type;
    over_type = ($urandom_range(0, 7) == 0) ? TYPE_NONE : TYPE_WIDTH'($urandom_range(1, 3));
    stride($urandom_range(0, 4), int'($urandom_range(0, 2)) - 1, DIST_ABOVE,
           TYPE_WIDTH'($urandom_range(0, 3)));
    stride($urandom_range(1, 3), int'($urandom_range(0, 2)) - 1, DIST_OVER, over_type);
    stride($urandom_range(5, 9), DIR_FWD, DIST_ANY, TYPE_WIDTH'($urandom_range(0, 3)));
    stride($urandom_range(2, 6), DIR_BACK, DIST_ANY, TYPE_WIDTH'($urandom_range(0, 3)));
    stride($urandom_range(5, 9), DIR_FWD, DIST_OVER, TYPE_WIDTH'($urandom_range(0, 3)));
    stride($urandom_range(1, 3), int'($urandom_range(0, 2)) - 1, DIST_CLEAR,
           TYPE_WIDTH'($urandom_range(0, 3)));
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int           gap;
    gait_result_t got;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 15);
      if (results_seen == HOLD_AT_RESULT) gap = HOLD_CYCLES;
      @(negedge clk);
      if (gap > 0) begin
        results_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      results_ch.ready = 1'b1;
      do @(posedge clk); while (!results_ch.valid);
      got.level = results_ch.perturb_level;
      got.fwd   = results_ch.moving_forward;
      got.bwd   = results_ch.moving_backward;
      got.phase = results_ch.phase;
      got.done  = results_ch.patch_done;
      sb.check_result(got);
      results_seen++;
    end
  end

  // Ends the run if no item moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("** gait_phase_perturbation_sequencer: FAILED **");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: field extremes, patch type zero, a full patch cycle
    // with repeated samples, then a flat window.
    send_sample(16'sd32767, 16'sd32767, 2'd3, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, TYPE_NONE, 1'b0);
    send_sample(16'sd0, 16'sd0, TYPE_NONE, 1'b0);
    send_sample(16'sd0, 16'sd0, 2'd2, 1'b0);
    send_sample(16'sd1000, 16'sd100, 2'd1, 1'b0);
    send_sample(16'sd800, 16'sd100, 2'd3, 1'b0);
    send_sample(16'sd800, -16'sd5, 2'd0, 1'b0);
    send_sample(16'sd500, 16'sd100, 2'd2, 1'b0);
    send_sample(-16'sd32768, 16'sd100, 2'd1, 1'b0);
    send_sample(16'sd0, -16'sd1, 2'd3, 1'b0);
    send_sample(16'sd300, -16'sd1, 2'd3, 1'b0);
    send_sample(16'sd200, -16'sd1, 2'd3, 1'b0);
    send_sample(16'sd100, -16'sd1, 2'd3, 1'b0);
    send_sample(16'sd0, -16'sd1, 2'd3, 1'b0);
    send_sample(-16'sd100, -16'sd1, 2'd3, 1'b0);
    send_sample(-16'sd200, -16'sd32768, 2'd3, 1'b0);
    send_sample(-16'sd200, 16'sd0, 2'd1, 1'b0);
    repeat (5) send_sample(16'sd7, 16'sd1, 2'd1, 1'b0);
    send_sample(16'sd7, 16'sd32767, 2'd1, 1'b0);
    cur_pos = 7;

    while (samples_sent < SAMPLE_TARGET) begin
      if ($urandom_range(0, 5) == 0)
        stride($urandom_range(1, 8), DIR_NOISE, DIST_ANY, TYPE_WIDTH'($urandom_range(0, 3)));
      else if ($urandom_range(0, 9) == 0)
        stride($urandom_range(5, 8), DIR_HOLD, DIST_ANY, TYPE_WIDTH'($urandom_range(0, 3)));
      else
        gait_cycle();
    end

    // Quit last, since only reset leaves the halted phase.
    send_sample(POS_WIDTH_DEF'($urandom), pick_distance(DIST_ANY),
                TYPE_WIDTH'($urandom_range(0, 3)), 1'b1);
    repeat (6) send_sample(POS_WIDTH_DEF'($urandom), pick_distance(DIST_ANY),
                           TYPE_WIDTH'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    @(negedge clk);
    samples_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** gait_phase_perturbation_sequencer: PASSED **");
    else
      $display("** gait_phase_perturbation_sequencer: FAILED **");
    $finish;
  end

endmodule

[gait_phase_perturbation_sequencer.f]
rtl/gpps_pkg.sv
rtl/gpps_in_if.sv
rtl/gpps_out_if.sv
rtl/gpps_front.sv
rtl/gpps_queue.sv
rtl/gpps_back.sv
rtl/gait_phase_perturbation_sequencer.sv
rtl/gpps_checker.sv
tb/gait_phase_perturbation_sequencer_test.sv
